@@ hdl/lsvr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack with value removal: shared types
// Request and response beat layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
package lsvr_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_e;

  localparam logic signed [31:0] EMPTY_TOP = -32'sd1;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic               is_empty;
    logic [4:0]         entry_count;
    status_e            status;
  } rsp_t;

endpackage
`default_nettype wire

@@ hdl/lsvr_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack with value removal: entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsvr_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/lifo_stack_with_value_removal_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack with value removal
// Bounded stack: push, pop, clear, and order-keeping removal of all entries
// equal to a word. Every request returns top, empty flag, count and status.
// ----------------------------------------------------------------------------
// Flow from accept to response: push, clear and pop on empty go straight to
// the response state; pop and push on full first read the top entry from the
// store; removal reads and compares each entry in turn (read state, then
// compare state), then reads the new top. One request in flight: the next is
// taken once the response registers, later while a response beat waits.
// Reset empties the stack (count zero); the store is not cleared.
module lifo_stack_with_value_removal_unit #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lsvr_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lsvr_pkg::rsp_t     out_rsp_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_RM_RD    = 6'b000010,
    S_RM_CMP   = 6'b000100,
    S_TOP_RD   = 6'b001000,
    S_TOP_WAIT = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         rd_q, rd_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic [WORD_WIDTH-1:0] word_q, word_d;
  logic signed [31:0]    top_q, top_d;
  lsvr_pkg::status_e     status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  lsvr_pkg::rsp_t        out_q, out_d;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [WORD_WIDTH-1:0] rdata;

  logic [WORD_WIDTH+31:0] in_ext;
  logic [WORD_WIDTH-1:0]  in_word;
  logic [WORD_WIDTH+31:0] rd_ext;
  logic [WORD_WIDTH+31:0] push_ext;
  logic [CW+4:0]          cnt_ext;
  logic [CW-1:0]          count_m1;
  logic [CW-1:0]          rd_p1;
  logic [CW-1:0]          wr_p1;

  assign in_ext   = {{WORD_WIDTH{1'b0}}, in_req_i.value};
  assign in_word  = in_ext[WORD_WIDTH-1:0];
  assign rd_ext   = {32'b0, rdata};
  assign push_ext = {32'b0, in_word};
  assign cnt_ext  = {5'b0, count_q};
  assign count_m1 = count_q - CW'(1);
  assign rd_p1    = rd_q + CW'(1);
  assign wr_p1    = wr_q + CW'(1);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  lsvr_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    word_d      = word_q;
    top_d       = top_q;
    status_d    = status_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = count_q[AW-1:0];
    wdata       = in_word;
    re          = 1'b0;
    raddr       = count_m1[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d   = in_word;
          status_d = lsvr_pkg::ST_OK;
          unique case (in_req_i.kind)
            lsvr_pkg::KIND_PUSH: begin
              if (count_q != FULL_CNT) begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
                top_d   = push_ext[31:0];
                state_d = S_DONE;
              end else begin
                status_d = lsvr_pkg::ST_FULL;
                state_d  = S_TOP_RD;
              end
            end
            lsvr_pkg::KIND_POP: begin
              if (count_q != '0) begin
                count_d = count_m1;
                state_d = S_TOP_RD;
              end else begin
                status_d = lsvr_pkg::ST_UNDERFLOW;
                top_d    = lsvr_pkg::EMPTY_TOP;
                state_d  = S_DONE;
              end
            end
            lsvr_pkg::KIND_CLEAR: begin
              count_d = '0;
              top_d   = lsvr_pkg::EMPTY_TOP;
              state_d = S_DONE;
            end
            lsvr_pkg::KIND_REMOVE: begin
              rd_d    = '0;
              wr_d    = '0;
              state_d = (count_q == '0) ? S_TOP_RD : S_RM_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RM_RD: begin
        re      = 1'b1;
        raddr   = rd_q[AW-1:0];
        state_d = S_RM_CMP;
      end
      S_RM_CMP: begin
        wdata = rdata;
        waddr = wr_q[AW-1:0];
        if (rdata != word_q) begin
          we   = 1'b1;
          wr_d = wr_p1;
        end
        rd_d = rd_p1;
        if (rd_p1 == count_q) begin
          count_d = wr_d;
          state_d = S_TOP_RD;
        end else begin
          state_d = S_RM_RD;
        end
      end
      S_TOP_RD: begin
        if (count_q == '0) begin
          top_d   = lsvr_pkg::EMPTY_TOP;
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          state_d = S_TOP_WAIT;
        end
      end
      S_TOP_WAIT: begin
        top_d   = rd_ext[31:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.top_value   = top_q;
          out_d.is_empty    = (count_q == '0);
          out_d.entry_count = cnt_ext[4:0];
          out_d.status      = status_q;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    wr_q     <= wr_d;
    word_q   <= word_d;
    top_q    <= top_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above depth");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RM_CMP) |-> (wr_q <= rd_q) && (rd_q < count_q))
    else $error("removal write pointer overtook read pointer");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_empty |-> out_q.top_value == lsvr_pkg::EMPTY_TOP)
    else $error("empty stack reports a top entry");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == lsvr_pkg::ST_UNDERFLOW) |-> out_q.is_empty)
    else $error("underflow reported on non-empty stack");

endmodule
`default_nettype wire
